>>> rtl/sa_pkg.sv
// Shared codes and the sequencer state type for the suffix automaton builder.
package sa_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int LETTER_W = 5;
  localparam int OCC_W    = 11;

  localparam logic [CMD_W-1:0] CMD_EXTEND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FINALIZE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_LETTER = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 2'd3;

  typedef enum logic [26:0] {
    S_CLR    = 27'h0000001,
    S_IDLE   = 27'h0000002,
    S_E_RD   = 27'h0000004,
    S_E_CHK  = 27'h0000008,
    S_E_RDQ  = 27'h0000010,
    S_E_CHKQ = 27'h0000020,
    S_COPY   = 27'h0000040,
    S_R_RD   = 27'h0000080,
    S_R_CHK  = 27'h0000100,
    S_E_FQ   = 27'h0000200,
    S_E_FC   = 27'h0000400,
    S_Z      = 27'h0000800,
    S_CN_RN  = 27'h0001000,
    S_CN_RB  = 27'h0002000,
    S_CN_WB  = 27'h0004000,
    S_P_RD   = 27'h0008000,
    S_P_WR   = 27'h0010000,
    S_X_RN   = 27'h0020000,
    S_X_RB   = 27'h0040000,
    S_X_WB   = 27'h0080000,
    S_A_RO   = 27'h0100000,
    S_A_RS   = 27'h0200000,
    S_A_RT   = 27'h0400000,
    S_A_WT   = 27'h0800000,
    S_Q_RL   = 27'h1000000,
    S_Q_FIN  = 27'h2000000,
    S_DONE   = 27'h4000000
  } state_t;

endpackage

>>> rtl/sa_trans_mem.sv
// Transition memory: one entry per state and letter, swept clear after reset.
module sa_trans_mem #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  output logic              busy
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [ADDR_W-1:0] clr_addr;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        busy <= 1'b0;
      end
    end
  end

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sa_node_mem.sv
// Per-state memory: link valid, suffix link, length, count, first position.
module sa_node_mem #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 44
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sa_sort_mem.sv
// Counting-sort storage: length buckets and the length-ordered state list.
module sa_sort_mem #(
  parameter int B_DEPTH = 1025,
  parameter int B_ADDR_W = 11,
  parameter int B_DATA_W = 12,
  parameter int O_DEPTH = 2048,
  parameter int O_ADDR_W = 11
) (
  input  logic                clk,
  input  logic [B_ADDR_W-1:0] b_addr,
  input  logic                b_we,
  input  logic [B_DATA_W-1:0] b_wdata,
  output logic [B_DATA_W-1:0] b_rdata,
  input  logic                o_we,
  input  logic [O_ADDR_W-1:0] o_waddr,
  input  logic [O_ADDR_W-1:0] o_wdata,
  input  logic [O_ADDR_W-1:0] o_raddr,
  output logic [O_ADDR_W-1:0] o_rdata
);

  logic [B_DATA_W-1:0] bucket [B_DEPTH];
  logic [O_ADDR_W-1:0] order [O_DEPTH];

  // bucket counts
  always_ff @(posedge clk) begin
    if (b_we) begin
      bucket[b_addr] <= b_wdata;
    end
    b_rdata <= bucket[b_addr];
  end

  // states in length order
  always_ff @(posedge clk) begin
    if (o_we) begin
      order[o_waddr] <= o_wdata;
    end
    o_rdata <= order[o_raddr];
  end

endmodule

>>> rtl/suffix_automaton_builder.sv
// Online suffix automaton builder: extend, finalize counts, query a state.
//
// One item in, one result out. Every step of the walks and sweeps goes through
// the single read port of the per-state memory. After reset the transition
// memory is swept clear, all 2**(SW+AW) entries (65536 at the default sizes),
// and no item is taken until the sweep ends.
module suffix_automaton_builder
  import sa_pkg::*;
#(
  parameter int MAX_TEXT = 1024,
  parameter int ALPHABET = 26,
  localparam int NS = 2 * MAX_TEXT,
  localparam int SW = $clog2(NS),
  localparam int LW = $clog2(MAX_TEXT + 1),
  localparam int PW = $clog2(MAX_TEXT)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    command,
  input  logic [LETTER_W-1:0] letter,
  input  logic [SW-1:0]       state_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [SW-1:0]       new_state,
  output logic                clone_made,
  output logic [LW-1:0]       interval_low,
  output logic [LW-1:0]       interval_high,
  output logic [OCC_W-1:0]    occur_count,
  output logic [PW-1:0]       first_end,
  output logic [SW-1:0]       link_out,
  output logic                link_valid
);

  localparam int CW  = SW + 1;
  localparam int AW  = $clog2(ALPHABET);
  localparam int LXW = (AW > LETTER_W) ? AW : LETTER_W;
  localparam int OW  = OCC_W;
  localparam int TW  = SW + 1;
  localparam int OCC_LSB  = PW;
  localparam int LEN_LSB  = PW + OW;
  localparam int LINK_LSB = PW + OW + LW;
  localparam int OK_BIT   = PW + OW + LW + SW;
  localparam int NW       = OK_BIT + 1;

  state_t state;

  logic [CW-1:0] states_used;
  logic [SW-1:0] last_state;
  logic [LW-1:0] last_len;

  logic [SW-1:0] p, cur, q, cl, cur_link, s_idx;
  logic [AW-1:0] c;
  logic [LW-1:0] cur_len, plen;
  logic [NW-1:0] q_word;
  logic [OW-1:0] s_occ;
  logic          clone;
  logic [AW:0]   k;
  logic [CW-1:0] i;
  logic [LW-1:0] l;
  logic [CW-1:0] acc;

  logic [STATUS_W-1:0] res_status;
  logic [SW-1:0]       res_new;
  logic                res_clone;
  logic [LW-1:0]       res_low, res_high;
  logic [OW-1:0]       res_occ;
  logic [PW-1:0]       res_fpos;
  logic [SW-1:0]       res_link;
  logic                res_lv;

  // memory ports
  logic [SW-1:0]    nd_raddr, nd_waddr;
  logic [NW-1:0]    nd_rd, nd_wdata;
  logic             nd_we;
  logic [SW+AW-1:0] tr_raddr, tr_waddr;
  logic [TW-1:0]    tr_rd, tr_wdata;
  logic             tr_we, tr_busy;
  logic [LW-1:0]    b_addr;
  logic             b_we;
  logic [CW-1:0]    b_wdata, b_rd;
  logic             o_we;
  logic [SW-1:0]    o_waddr, o_wdata, o_raddr, o_rd;

  sa_trans_mem #(.ADDR_W(SW + AW), .DATA_W(TW)) u_trans (
    .clk(clk), .rst(rst), .raddr(tr_raddr), .rdata(tr_rd),
    .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata), .busy(tr_busy)
  );

  sa_node_mem #(.ADDR_W(SW), .DATA_W(NW)) u_node (
    .clk(clk), .raddr(nd_raddr), .rdata(nd_rd),
    .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata)
  );

  sa_sort_mem #(
    .B_DEPTH(MAX_TEXT + 1), .B_ADDR_W(LW), .B_DATA_W(CW),
    .O_DEPTH(NS), .O_ADDR_W(SW)
  ) u_sort (
    .clk(clk), .b_addr(b_addr), .b_we(b_we), .b_wdata(b_wdata), .b_rdata(b_rd),
    .o_we(o_we), .o_waddr(o_waddr), .o_wdata(o_wdata), .o_raddr(o_raddr),
    .o_rdata(o_rd)
  );

  // decoded read data
  logic          nd_ok;
  logic [SW-1:0] nd_link;
  logic [LW-1:0] nd_len;
  logic [OW-1:0] nd_occ;
  logic [PW-1:0] nd_fpos;
  logic          tv;
  logic [SW-1:0] tt;

  assign nd_ok   = nd_rd[OK_BIT];
  assign nd_link = nd_rd[LINK_LSB +: SW];
  assign nd_len  = nd_rd[LEN_LSB +: LW];
  assign nd_occ  = nd_rd[OCC_LSB +: OW];
  assign nd_fpos = nd_rd[PW-1:0];
  assign tv      = tr_rd[SW];
  assign tt      = tr_rd[SW-1:0];

  // input checks
  logic [LXW-1:0] letter_x;
  logic [AW-1:0]  letter_idx;
  logic           letter_bad, store_full, index_bad, accept;

  assign letter_x   = LXW'(letter);
  assign letter_idx = letter_x[AW-1:0];
  assign letter_bad = int'(letter) >= ALPHABET;
  assign store_full = (int'(last_len) >= MAX_TEXT) || (int'(states_used) + 2 > NS);
  assign index_bad  = {1'b0, state_index} >= states_used;
  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;

  // helpers
  logic [LW-1:0] ln;
  logic [OW:0]   occ_sum;
  logic [OW-1:0] occ_new;
  logic [CW-1:0] im1, ip1, b_dec, b_acc;
  logic [AW:0]   km1;
  logic          out_free;

  assign ln      = (nd_len > last_len) ? last_len : nd_len;
  assign occ_sum = {1'b0, nd_occ} + {1'b0, s_occ};
  assign occ_new = occ_sum[OW] ? {OW{1'b1}} : occ_sum[OW-1:0];
  assign im1     = i - 1'b1;
  assign ip1     = i + 1'b1;
  assign b_dec   = b_rd - 1'b1;
  assign b_acc   = acc + b_rd;
  assign km1     = k - 1'b1;
  assign out_free = !out_valid || !out_stall;

  // memory addressing and writes by sequencer state
  always_comb begin
    nd_raddr = last_state;
    nd_we    = 1'b0;
    nd_waddr = cur;
    nd_wdata = '0;
    tr_raddr = {p, c};
    tr_we    = 1'b0;
    tr_waddr = {p, c};
    tr_wdata = '0;
    b_addr   = l;
    b_we     = 1'b0;
    b_wdata  = '0;
    o_we     = 1'b0;
    o_waddr  = b_dec[SW-1:0];
    o_wdata  = im1[SW-1:0];
    o_raddr  = im1[SW-1:0];
    case (state)
      S_CLR: begin
        nd_we    = 1'b1;
        nd_waddr = '0;
      end
      S_IDLE: begin
        nd_raddr = (command == CMD_QUERY) ? state_index : last_state;
        tr_raddr = {last_state, letter_idx};
      end
      S_E_RD, S_R_RD: begin
        nd_raddr = p;
      end
      S_E_CHK: begin
        if (!tv) begin
          tr_we    = 1'b1;
          tr_wdata = {1'b1, cur};
        end
      end
      S_E_RDQ: begin
        nd_raddr = q;
      end
      S_E_CHKQ: begin
        if (nd_len != plen + 1'b1) begin
          nd_we    = 1'b1;
          nd_waddr = states_used[SW-1:0];
          nd_wdata = {nd_ok, nd_link, plen + 1'b1, {OW{1'b0}}, nd_fpos};
        end
      end
      S_COPY: begin
        tr_raddr = {q, k[AW-1:0]};
        tr_waddr = {cl, km1[AW-1:0]};
        tr_wdata = tr_rd;
        tr_we    = (k != '0);
      end
      S_R_CHK: begin
        if (tv && tt == q) begin
          tr_we    = 1'b1;
          tr_wdata = {1'b1, cl};
        end
      end
      S_E_FQ: begin
        nd_we    = 1'b1;
        nd_waddr = q;
        nd_wdata = {1'b1, cl, q_word[LEN_LSB +: LW], q_word[OCC_LSB +: OW],
                    q_word[PW-1:0]};
      end
      S_E_FC: begin
        nd_we    = 1'b1;
        nd_waddr = cur;
        nd_wdata = {1'b1, cur_link, cur_len, OW'(1), PW'(cur_len - 1'b1)};
      end
      S_Z: begin
        b_we = 1'b1;
      end
      S_CN_RN: begin
        nd_raddr = i[SW-1:0];
      end
      S_CN_RB, S_X_RB: begin
        b_addr = ln;
      end
      S_CN_WB: begin
        b_we    = 1'b1;
        b_wdata = b_rd + 1'b1;
      end
      S_P_WR: begin
        b_we    = 1'b1;
        b_wdata = b_acc;
      end
      S_X_RN: begin
        nd_raddr = im1[SW-1:0];
      end
      S_X_WB: begin
        b_we    = 1'b1;
        b_wdata = b_dec;
        o_we    = 1'b1;
      end
      S_A_RS: begin
        nd_raddr = o_rd;
      end
      S_A_RT, S_Q_RL: begin
        nd_raddr = nd_link;
      end
      S_A_WT: begin
        nd_we    = 1'b1;
        nd_waddr = cur_link;
        nd_wdata = {nd_ok, nd_link, nd_len, occ_new, nd_fpos};
      end
      default: begin
      end
    endcase
  end

  // sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      states_used <= CW'(1);
      last_state  <= '0;
      last_len    <= '0;
    end else begin
      case (state)
        S_CLR: begin
          if (!tr_busy) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_clone  <= 1'b0;
            res_low    <= '0;
            res_high   <= '0;
            res_occ    <= '0;
            res_fpos   <= '0;
            res_link   <= '0;
            res_lv     <= 1'b0;
            case (command)
              CMD_EXTEND: begin
                if (letter_bad) begin
                  res_status <= ST_BAD_LETTER;
                  res_new    <= '0;
                  state      <= S_DONE;
                end else if (store_full) begin
                  res_status <= ST_FULL;
                  res_new    <= '0;
                  state      <= S_DONE;
                end else begin
                  res_status  <= ST_OK;
                  cur         <= states_used[SW-1:0];
                  cur_len     <= last_len + 1'b1;
                  cur_link    <= '0;
                  res_new     <= states_used[SW-1:0];
                  states_used <= states_used + 1'b1;
                  last_state  <= states_used[SW-1:0];
                  last_len    <= last_len + 1'b1;
                  p           <= last_state;
                  c           <= letter_idx;
                  clone       <= 1'b0;
                  state       <= S_E_CHK;
                end
              end
              CMD_FINALIZE: begin
                res_status <= ST_OK;
                res_new    <= '0;
                l          <= '0;
                state      <= S_Z;
              end
              CMD_QUERY: begin
                res_new <= '0;
                p       <= state_index;
                if (index_bad) begin
                  res_status <= ST_BAD_INDEX;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_Q_RL;
                end
              end
              default: begin
                res_status <= ST_OK;
                res_new    <= '0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        // walk suffix links adding the new transition
        S_E_RD: begin
          state <= S_E_CHK;
        end
        S_E_CHK: begin
          if (!tv) begin
            if (!nd_ok) begin
              cur_link <= '0;
              state    <= S_E_FC;
            end else begin
              p     <= nd_link;
              state <= S_E_RD;
            end
          end else begin
            q     <= tt;
            plen  <= nd_len;
            state <= S_E_RDQ;
          end
        end
        S_E_RDQ: begin
          state <= S_E_CHKQ;
        end
        S_E_CHKQ: begin
          if (nd_len == plen + 1'b1) begin
            cur_link <= q;
            state    <= S_E_FC;
          end else begin
            cl          <= states_used[SW-1:0];
            states_used <= states_used + 1'b1;
            q_word      <= nd_rd;
            clone       <= 1'b1;
            k           <= '0;
            state       <= S_COPY;
          end
        end
        // copy the row of q into the clone
        S_COPY: begin
          if (k == (AW+1)'(ALPHABET)) begin
            state <= S_R_RD;
          end else begin
            k <= k + 1'b1;
          end
        end
        // redirect transitions from q to the clone
        S_R_RD: begin
          state <= S_R_CHK;
        end
        S_R_CHK: begin
          if (tv && tt == q && nd_ok) begin
            p     <= nd_link;
            state <= S_R_RD;
          end else begin
            state <= S_E_FQ;
          end
        end
        S_E_FQ: begin
          cur_link <= cl;
          state    <= S_E_FC;
        end
        S_E_FC: begin
          res_clone <= clone;
          state     <= S_DONE;
        end
        // finalize: clear buckets
        S_Z: begin
          if (l == last_len) begin
            i     <= '0;
            state <= S_CN_RN;
          end else begin
            l <= l + 1'b1;
          end
        end
        // count states per length
        S_CN_RN: begin
          state <= S_CN_RB;
        end
        S_CN_RB: begin
          l     <= ln;
          state <= S_CN_WB;
        end
        S_CN_WB: begin
          i <= ip1;
          if (ip1 == states_used) begin
            l     <= '0;
            acc   <= '0;
            state <= S_P_RD;
          end else begin
            state <= S_CN_RN;
          end
        end
        // prefix sums
        S_P_RD: begin
          state <= S_P_WR;
        end
        S_P_WR: begin
          acc <= b_acc;
          if (l == last_len) begin
            i     <= states_used;
            state <= S_X_RN;
          end else begin
            l     <= l + 1'b1;
            state <= S_P_RD;
          end
        end
        // place states in length order, last first
        S_X_RN: begin
          state <= S_X_RB;
        end
        S_X_RB: begin
          l     <= ln;
          state <= S_X_WB;
        end
        S_X_WB: begin
          if (im1 == '0) begin
            i     <= states_used;
            state <= S_A_RO;
          end else begin
            i     <= im1;
            state <= S_X_RN;
          end
        end
        // add counts into suffix links, longest first
        S_A_RO: begin
          state <= S_A_RS;
        end
        S_A_RS: begin
          s_idx <= o_rd;
          state <= S_A_RT;
        end
        S_A_RT: begin
          if (s_idx == '0 || !nd_ok) begin
            i     <= im1;
            state <= (im1 == '0) ? S_DONE : S_A_RO;
          end else begin
            s_occ    <= nd_occ;
            cur_link <= nd_link;
            state    <= S_A_WT;
          end
        end
        S_A_WT: begin
          i     <= im1;
          state <= (im1 == '0) ? S_DONE : S_A_RO;
        end
        // query
        S_Q_RL: begin
          res_high <= nd_len;
          res_occ  <= nd_occ;
          res_fpos <= nd_fpos;
          res_link <= nd_ok ? nd_link : '0;
          res_lv   <= nd_ok;
          if (nd_ok && p != '0) begin
            state <= S_Q_FIN;
          end else begin
            state <= S_DONE;
          end
        end
        S_Q_FIN: begin
          res_low <= nd_len + 1'b1;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status        <= res_status;
      new_state     <= res_new;
      clone_made    <= res_clone;
      interval_low  <= res_low;
      interval_high <= res_high;
      occur_count   <= res_occ;
      first_end     <= res_fpos;
      link_out      <= res_link;
      link_valid    <= res_lv;
    end
  end

`ifndef SYNTH
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    (states_used != '0) && (int'(states_used) <= NS))
    else $error("state count out of range");

  a_last_in_use: assert property (@(posedge clk) disable iff (rst)
    {1'b0, last_state} < states_used)
    else $error("last state beyond used states");

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !tr_busy)
    else $error("item taken during transition clear");

  a_extend_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_E_FC) |=> (last_len != '0) && (cur == last_state))
    else $error("extend finished without a new last state");
`endif

endmodule
